>>> hw/rtl/lavm_pkg.sv
// Shared types and constants for the look-at view matrix pipeline.
`default_nettype none

package lavm_pkg;

    // Component width of vectors handed to the normalizer
    localparam int VEC_W = 48;
    // Width of the bundle that rides alongside a vector through the normalizer
    localparam int SIDE_W = 192;

    // Squared length threshold in Q.60, the square of Q.30 (length 0.0001)
    localparam logic [63:0] NORM_MIN_SQ = 64'd11529215047;

    // Normalizer stage map
    localparam int NS_MAG = 0;
    localparam int NS_MAX = 1;
    localparam int NS_SUM = 2;
    localparam int NS_SHF = 3;
    localparam int NS_SQ  = 4;
    localparam int NS_TOT = 5;
    localparam int NS_RT0 = 6;
    localparam int RT_STEPS = 32;
    localparam int NS_DV0 = NS_RT0 + RT_STEPS;
    localparam int DV_STEPS = 31;
    localparam int NS_OUT = NS_DV0 + DV_STEPS;
    localparam int NORM_STAGES = NS_OUT + 1;

    typedef struct packed {
        logic signed [31:0] eye_x;
        logic signed [31:0] eye_y;
        logic signed [31:0] eye_z;
        logic signed [31:0] center_x;
        logic signed [31:0] center_y;
        logic signed [31:0] center_z;
        logic signed [15:0] upvec_x;
        logic signed [15:0] upvec_y;
        logic signed [15:0] upvec_z;
    } lavm_in_t;

    typedef struct packed {
        logic signed [15:0] side_x;
        logic signed [15:0] side_y;
        logic signed [15:0] side_z;
        logic signed [15:0] true_up_x;
        logic signed [15:0] true_up_y;
        logic signed [15:0] true_up_z;
        logic signed [15:0] back_x;
        logic signed [15:0] back_y;
        logic signed [15:0] back_z;
        logic signed [31:0] shift_x;
        logic signed [31:0] shift_y;
        logic signed [31:0] shift_z;
    } lavm_out_t;

    // Vector plus side bundle at the normalizer ports
    typedef struct packed {
        logic [SIDE_W-1:0]          side;
        logic [2:0][VEC_W-1:0]      vec;
    } lavm_nvec_t;

    // Side bundle around the forward normalization
    typedef struct packed {
        logic [47:0]       pad;
        logic [2:0][31:0]  eye;
        logic [2:0][15:0]  up;
    } lavm_side1_t;

    // Side bundle around the side-vector normalization
    typedef struct packed {
        logic [2:0][31:0]  fwd;
        logic [2:0][31:0]  eye;
    } lavm_side2_t;

    // Working record of one normalizer stage
    typedef struct packed {
        logic [SIDE_W-1:0]      side;
        logic [2:0][VEC_W-1:0]  raw;
        logic [2:0]             neg;
        logic [2:0][VEC_W-1:0]  mag;
        logic [VEC_W-1:0]       maxv;
        logic [2:0][61:0]       sq;
        logic                   narrow;
        logic                   skip;
        logic [5:0]             bl;
        logic [2:0][30:0]       num;
        logic [63:0]            rad;
        logic [31:0]            root;
        logic [33:0]            rem;
        logic [2:0][32:0]       drem;
        logic [2:0][30:0]       quo;
    } lavm_nitem_t;

endpackage

`default_nettype wire

>>> hw/rtl/lavm_norm.sv
// Pipelined 3-vector normalizer: bit-per-stage square root and divide.
`default_nettype none

module lavm_norm (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               adv,
    input  logic               in_valid,
    input  lavm_pkg::lavm_nvec_t in_item,
    output logic               out_valid,
    output lavm_pkg::lavm_nvec_t out_item
);

    function automatic logic [5:0] bitlen48(input logic [47:0] v);
        logic [5:0] n;
        n = '0;
        for (int i = 0; i < 48; i++)
        begin
            if (v[i])
            begin
                n = 6'(i + 1);
            end
        end
        return n;
    endfunction

    function automatic lavm_pkg::lavm_nitem_t stage_fn(input int k,
                                                       input lavm_pkg::lavm_nitem_t x);
        lavm_pkg::lavm_nitem_t o;
        logic [35:0] trial;
        logic [35:0] tq;
        logic [32:0] cur;
        logic        qb;
        o = x;
        if (k == lavm_pkg::NS_MAG)
        begin
            for (int i = 0; i < 3; i++)
            begin
                o.neg[i] = x.raw[i][47];
                o.mag[i] = x.raw[i][47] ? (48'd0 - x.raw[i]) : x.raw[i];
            end
        end
        else if (k == lavm_pkg::NS_MAX)
        begin
            o.maxv = x.mag[0];
            if (x.mag[1] > o.maxv)
            begin
                o.maxv = x.mag[1];
            end
            if (x.mag[2] > o.maxv)
            begin
                o.maxv = x.mag[2];
            end
            for (int i = 0; i < 3; i++)
            begin
                o.sq[i] = x.mag[i][30:0] * x.mag[i][30:0];
            end
            o.narrow = (x.mag[0][47:31] == '0) && (x.mag[1][47:31] == '0)
                       && (x.mag[2][47:31] == '0);
        end
        else if (k == lavm_pkg::NS_SUM)
        begin
            o.rad  = 64'(x.sq[0]) + 64'(x.sq[1]) + 64'(x.sq[2]);
            o.skip = x.narrow && (o.rad < lavm_pkg::NORM_MIN_SQ);
            o.bl   = bitlen48(x.maxv);
        end
        else if (k == lavm_pkg::NS_SHF)
        begin
            // bring the largest magnitude into [2^30, 2^31)
            for (int i = 0; i < 3; i++)
            begin
                if (x.bl > 6'd31)
                begin
                    o.num[i] = 31'(x.mag[i] >> (x.bl - 6'd31));
                end
                else
                begin
                    o.num[i] = 31'(x.mag[i] << (6'd31 - x.bl));
                end
            end
        end
        else if (k == lavm_pkg::NS_SQ)
        begin
            for (int i = 0; i < 3; i++)
            begin
                o.sq[i] = x.num[i] * x.num[i];
            end
        end
        else if (k == lavm_pkg::NS_TOT)
        begin
            o.rad  = 64'(x.sq[0]) + 64'(x.sq[1]) + 64'(x.sq[2]);
            o.root = '0;
            o.rem  = '0;
        end
        else if (k < lavm_pkg::NS_DV0)
        begin
            // one root bit per stage
            trial = {x.rem, x.rad[63:62]};
            tq    = {2'b00, x.root, 2'b01};
            if (trial >= tq)
            begin
                o.rem  = 34'(trial - tq);
                o.root = {x.root[30:0], 1'b1};
            end
            else
            begin
                o.rem  = trial[33:0];
                o.root = {x.root[30:0], 1'b0};
            end
            o.rad = {x.rad[61:0], 2'b00};
        end
        else if (k < lavm_pkg::NS_OUT)
        begin
            // one quotient bit per stage, all three lanes
            for (int i = 0; i < 3; i++)
            begin
                cur = (k == lavm_pkg::NS_DV0) ? {2'b00, x.num[i]} : x.drem[i];
                qb  = 1'b0;
                if (cur >= {1'b0, x.root})
                begin
                    cur = cur - {1'b0, x.root};
                    qb  = 1'b1;
                end
                o.drem[i] = {cur[31:0], 1'b0};
                o.quo[i]  = {x.quo[i][29:0], qb};
            end
        end
        else
        begin
            for (int i = 0; i < 3; i++)
            begin
                if (!x.skip)
                begin
                    o.raw[i] = x.neg[i] ? (48'd0 - {17'd0, x.quo[i]}) : {17'd0, x.quo[i]};
                end
            end
        end
        return o;
    endfunction

    lavm_pkg::lavm_nitem_t st_reg  [lavm_pkg::NORM_STAGES];
    lavm_pkg::lavm_nitem_t st_src  [lavm_pkg::NORM_STAGES];
    lavm_pkg::lavm_nitem_t st_next [lavm_pkg::NORM_STAGES];
    logic [lavm_pkg::NORM_STAGES-1:0] vld_reg;
    lavm_pkg::lavm_nitem_t seed;

    always_comb
    begin
        seed      = '0;
        seed.side = in_item.side;
        seed.raw  = in_item.vec;
    end

    for (genvar k = 0; k < lavm_pkg::NORM_STAGES; k++)
    begin : g_stage
        if (k == 0)
        begin : g_first
            assign st_src[k] = seed;
        end
        else
        begin : g_rest
            assign st_src[k] = st_reg[k-1];
        end

        always_comb
        begin
            st_next[k] = stage_fn(k, st_src[k]);
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                st_reg[k] <= st_next[k];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[lavm_pkg::NORM_STAGES-2:0], in_valid};
        end
    end

    assign out_valid     = vld_reg[lavm_pkg::NORM_STAGES-1];
    assign out_item.side = st_reg[lavm_pkg::NORM_STAGES-1].side;
    assign out_item.vec  = st_reg[lavm_pkg::NORM_STAGES-1].raw;

endmodule

`default_nettype wire

>>> hw/rtl/look_at_view_matrix_core.sv
// Top level of the look-at view matrix pipeline.
`default_nettype none

// Fully pipelined look-at camera: one transaction (eye, center, up) enters per
// clock while cmd_stall is low and yields one view matrix (rotation rows in
// Q2.14, translation in Q16.16). The pipeline depth is set by the two
// 70-stage normalizers (a 32-stage square root and a 31-stage divider each)
// plus the cross-product, dot-product and rounding stages. Throughput is one
// transaction per cycle while cmd_stall is low; a one-entry skid stage behind
// the output register parks the transaction leaving the pipeline when
// res_stall holds the output, and cmd_stall is high while that entry is occupied.
module look_at_view_matrix_core (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cmd_valid,
    output logic                cmd_stall,
    input  lavm_pkg::lavm_in_t  cmd,
    output logic                res_valid,
    input  logic                res_stall,
    output lavm_pkg::lavm_out_t res
);

    function automatic logic signed [47:0] rnd_shift14(input logic signed [48:0] x);
        logic [48:0] mag;
        logic [48:0] m;
        mag = x[48] ? 49'(-x) : 49'(x);
        m   = (mag + 49'd8192) >> 14;
        return x[48] ? 48'(-m) : 48'(m);
    endfunction

    function automatic logic signed [47:0] rnd_shift30(input logic signed [64:0] x);
        logic [64:0] mag;
        logic [64:0] m;
        mag = x[64] ? 65'(-x) : 65'(x);
        m   = (mag + 65'h2000_0000) >> 30;
        return x[64] ? 48'(-m) : 48'(m);
    endfunction

    function automatic logic signed [15:0] row16(input logic signed [47:0] x);
        logic [47:0] mag;
        logic [47:0] m;
        logic [15:0] r;
        mag = x[47] ? 48'(-x) : 48'(x);
        m   = (mag + 48'h8000) >> 16;
        if (x[47])
        begin
            r = (m > 48'd32768) ? 16'h8000 : 16'(-m);
        end
        else
        begin
            r = (m > 48'd32767) ? 16'h7fff : 16'(m);
        end
        return r;
    endfunction

    function automatic logic signed [31:0] shift32(input logic signed [67:0] x);
        logic [67:0] mag;
        logic [67:0] m;
        logic [31:0] r;
        mag = x[67] ? 68'(-x) : 68'(x);
        m   = (mag + 68'h2000_0000) >> 30;
        if (x[67])
        begin
            r = (m > 68'h8000_0000) ? 32'h8000_0000 : 32'(-m);
        end
        else
        begin
            r = (m > 68'h7fff_ffff) ? 32'h7fff_ffff : 32'(m);
        end
        return r;
    endfunction

    logic adv;
    logic skid_valid_reg, res_valid_reg;
    lavm_pkg::lavm_out_t skid_reg, res_reg;

    assign adv       = !skid_valid_reg;
    assign cmd_stall = skid_valid_reg;

    // ---------------- T0: forward difference ----------------
    logic               t0_valid_reg;
    logic signed [31:0] t0_eye_reg [3];
    logic signed [15:0] t0_up_reg  [3];
    logic signed [47:0] t0_f_reg   [3];
    logic signed [31:0] t0_eye_next [3];
    logic signed [31:0] t0_ctr [3];
    logic signed [15:0] t0_up_next [3];
    logic signed [47:0] t0_f_next  [3];
    logic [32:0]        t0_d [3];

    always_comb
    begin
        t0_eye_next[0] = cmd.eye_x;
        t0_eye_next[1] = cmd.eye_y;
        t0_eye_next[2] = cmd.eye_z;
        t0_ctr[0]      = cmd.center_x;
        t0_ctr[1]      = cmd.center_y;
        t0_ctr[2]      = cmd.center_z;
        t0_up_next[0]  = cmd.upvec_x;
        t0_up_next[1]  = cmd.upvec_y;
        t0_up_next[2]  = cmd.upvec_z;
        for (int i = 0; i < 3; i++)
        begin
            t0_d[i]      = {t0_ctr[i][31], t0_ctr[i]} - {t0_eye_next[i][31], t0_eye_next[i]};
            t0_f_next[i] = {t0_d[i][32], t0_d[i], 14'd0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            t0_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            t0_valid_reg <= cmd_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            t0_eye_reg <= t0_eye_next;
            t0_up_reg  <= t0_up_next;
            t0_f_reg   <= t0_f_next;
        end
    end

    // ---------------- forward normalization ----------------
    lavm_pkg::lavm_nvec_t  n1_in, n1_out;
    lavm_pkg::lavm_side1_t n1_side_in, n1_side_out;
    logic                  n1_valid;

    always_comb
    begin
        n1_side_in.pad = '0;
        for (int i = 0; i < 3; i++)
        begin
            n1_side_in.eye[i] = t0_eye_reg[i];
            n1_side_in.up[i]  = t0_up_reg[i];
            n1_in.vec[i]      = t0_f_reg[i];
        end
        n1_in.side = n1_side_in;
    end

    lavm_norm u_norm_fwd (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .in_valid (t0_valid_reg),
        .in_item  (n1_in),
        .out_valid(n1_valid),
        .out_item (n1_out)
    );

    assign n1_side_out = lavm_pkg::lavm_side1_t'(n1_out.side);

    // ---------------- T1: f x up products ----------------
    logic               t1_valid_reg;
    logic signed [31:0] t1_f_reg   [3];
    logic signed [31:0] t1_eye_reg [3];
    logic signed [47:0] t1_pa_reg  [3];
    logic signed [47:0] t1_pb_reg  [3];
    logic signed [31:0] t1_f_next  [3];
    logic signed [31:0] t1_eye_next [3];
    logic signed [15:0] t1_up [3];
    logic signed [47:0] t1_pa_next [3];
    logic signed [47:0] t1_pb_next [3];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            t1_f_next[i]   = n1_out.vec[i][31:0];
            t1_eye_next[i] = n1_side_out.eye[i];
            t1_up[i]       = n1_side_out.up[i];
        end
        t1_pa_next[0] = t1_f_next[1] * t1_up[2];
        t1_pb_next[0] = t1_f_next[2] * t1_up[1];
        t1_pa_next[1] = t1_f_next[2] * t1_up[0];
        t1_pb_next[1] = t1_f_next[0] * t1_up[2];
        t1_pa_next[2] = t1_f_next[0] * t1_up[1];
        t1_pb_next[2] = t1_f_next[1] * t1_up[0];
    end

    // ---------------- T2: side vector, Q.30 ----------------
    logic               t2_valid_reg;
    logic signed [31:0] t2_f_reg   [3];
    logic signed [31:0] t2_eye_reg [3];
    logic signed [47:0] t2_s_reg   [3];
    logic signed [48:0] t2_diff    [3];
    logic signed [47:0] t2_s_next  [3];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            t2_diff[i]   = t1_pa_reg[i] - t1_pb_reg[i];
            t2_s_next[i] = rnd_shift14(t2_diff[i]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            t1_valid_reg <= 1'b0;
            t2_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            t1_valid_reg <= n1_valid;
            t2_valid_reg <= t1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            t1_f_reg   <= t1_f_next;
            t1_eye_reg <= t1_eye_next;
            t1_pa_reg  <= t1_pa_next;
            t1_pb_reg  <= t1_pb_next;
            t2_f_reg   <= t1_f_reg;
            t2_eye_reg <= t1_eye_reg;
            t2_s_reg   <= t2_s_next;
        end
    end

    // ---------------- side normalization ----------------
    lavm_pkg::lavm_nvec_t  n2_in, n2_out;
    lavm_pkg::lavm_side2_t n2_side_in, n2_side_out;
    logic                  n2_valid;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            n2_side_in.fwd[i] = t2_f_reg[i];
            n2_side_in.eye[i] = t2_eye_reg[i];
            n2_in.vec[i]      = t2_s_reg[i];
        end
        n2_in.side = n2_side_in;
    end

    lavm_norm u_norm_side (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .in_valid (t2_valid_reg),
        .in_item  (n2_in),
        .out_valid(n2_valid),
        .out_item (n2_out)
    );

    assign n2_side_out = lavm_pkg::lavm_side2_t'(n2_out.side);

    // ---------------- T3: u, s.eye and f.eye products ----------------
    logic               t3_valid_reg;
    logic signed [31:0] t3_s_reg   [3];
    logic signed [31:0] t3_f_reg   [3];
    logic signed [31:0] t3_eye_reg [3];
    logic signed [63:0] t3_ua_reg  [3];
    logic signed [63:0] t3_ub_reg  [3];
    logic signed [63:0] t3_ds_reg  [3];
    logic signed [63:0] t3_df_reg  [3];
    logic signed [31:0] t3_s_next  [3];
    logic signed [31:0] t3_f_next  [3];
    logic signed [31:0] t3_eye_next [3];
    logic signed [63:0] t3_ua_next [3];
    logic signed [63:0] t3_ub_next [3];
    logic signed [63:0] t3_ds_next [3];
    logic signed [63:0] t3_df_next [3];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            t3_s_next[i]   = n2_out.vec[i][31:0];
            t3_f_next[i]   = n2_side_out.fwd[i];
            t3_eye_next[i] = n2_side_out.eye[i];
        end
        t3_ua_next[0] = t3_s_next[1] * t3_f_next[2];
        t3_ub_next[0] = t3_s_next[2] * t3_f_next[1];
        t3_ua_next[1] = t3_s_next[2] * t3_f_next[0];
        t3_ub_next[1] = t3_s_next[0] * t3_f_next[2];
        t3_ua_next[2] = t3_s_next[0] * t3_f_next[1];
        t3_ub_next[2] = t3_s_next[1] * t3_f_next[0];
        for (int i = 0; i < 3; i++)
        begin
            t3_ds_next[i] = t3_s_next[i] * t3_eye_next[i];
            t3_df_next[i] = t3_f_next[i] * t3_eye_next[i];
        end
    end

    // ---------------- T4: round u, sum s.eye and f.eye ----------------
    logic               t4_valid_reg;
    logic signed [31:0] t4_s_reg   [3];
    logic signed [31:0] t4_f_reg   [3];
    logic signed [31:0] t4_eye_reg [3];
    logic signed [47:0] t4_u_reg   [3];
    logic signed [67:0] t4_ds_reg, t4_df_reg;
    logic signed [64:0] t4_diff [3];
    logic signed [47:0] t4_u_next [3];
    logic signed [67:0] t4_ds_next, t4_df_next;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            t4_diff[i]   = t3_ua_reg[i] - t3_ub_reg[i];
            t4_u_next[i] = rnd_shift30(t4_diff[i]);
        end
        t4_ds_next = t3_ds_reg[0] + t3_ds_reg[1] + t3_ds_reg[2];
        t4_df_next = t3_df_reg[0] + t3_df_reg[1] + t3_df_reg[2];
    end

    // ---------------- T5: u.eye products ----------------
    logic               t5_valid_reg;
    logic signed [31:0] t5_s_reg [3];
    logic signed [31:0] t5_f_reg [3];
    logic signed [47:0] t5_u_reg [3];
    logic signed [67:0] t5_ds_reg, t5_df_reg;
    logic signed [67:0] t5_du_reg  [3];
    logic signed [32:0] t5_un      [3];
    logic signed [67:0] t5_du_next [3];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            t5_un[i]      = t4_u_reg[i][32:0];
            t5_du_next[i] = t5_un[i] * t4_eye_reg[i];
        end
    end

    // ---------------- T6: u.eye sum ----------------
    logic               t6_valid_reg;
    logic signed [31:0] t6_s_reg [3];
    logic signed [31:0] t6_f_reg [3];
    logic signed [47:0] t6_u_reg [3];
    logic signed [67:0] t6_ds_reg, t6_df_reg, t6_du_reg;
    logic signed [67:0] t6_du_next;

    assign t6_du_next = t5_du_reg[0] + t5_du_reg[1] + t5_du_reg[2];

    // ---------------- T7: round and saturate ----------------
    logic                t7_valid_reg;
    lavm_pkg::lavm_out_t t7_res_reg, t7_res_next;
    logic signed [47:0]  t7_sw [3];
    logic signed [47:0]  t7_bk [3];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            t7_sw[i] = t6_s_reg[i];
            t7_bk[i] = -48'(t6_f_reg[i]);
        end
        t7_res_next.side_x    = row16(t7_sw[0]);
        t7_res_next.side_y    = row16(t7_sw[1]);
        t7_res_next.side_z    = row16(t7_sw[2]);
        t7_res_next.true_up_x = row16(t6_u_reg[0]);
        t7_res_next.true_up_y = row16(t6_u_reg[1]);
        t7_res_next.true_up_z = row16(t6_u_reg[2]);
        t7_res_next.back_x    = row16(t7_bk[0]);
        t7_res_next.back_y    = row16(t7_bk[1]);
        t7_res_next.back_z    = row16(t7_bk[2]);
        t7_res_next.shift_x   = shift32(-t6_ds_reg);
        t7_res_next.shift_y   = shift32(-t6_du_reg);
        t7_res_next.shift_z   = shift32(t6_df_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            t3_valid_reg <= 1'b0;
            t4_valid_reg <= 1'b0;
            t5_valid_reg <= 1'b0;
            t6_valid_reg <= 1'b0;
            t7_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            t3_valid_reg <= n2_valid;
            t4_valid_reg <= t3_valid_reg;
            t5_valid_reg <= t4_valid_reg;
            t6_valid_reg <= t5_valid_reg;
            t7_valid_reg <= t6_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            t3_s_reg   <= t3_s_next;
            t3_f_reg   <= t3_f_next;
            t3_eye_reg <= t3_eye_next;
            t3_ua_reg  <= t3_ua_next;
            t3_ub_reg  <= t3_ub_next;
            t3_ds_reg  <= t3_ds_next;
            t3_df_reg  <= t3_df_next;
            t4_s_reg   <= t3_s_reg;
            t4_f_reg   <= t3_f_reg;
            t4_eye_reg <= t3_eye_reg;
            t4_u_reg   <= t4_u_next;
            t4_ds_reg  <= t4_ds_next;
            t4_df_reg  <= t4_df_next;
            t5_s_reg   <= t4_s_reg;
            t5_f_reg   <= t4_f_reg;
            t5_u_reg   <= t4_u_reg;
            t5_ds_reg  <= t4_ds_reg;
            t5_df_reg  <= t4_df_reg;
            t5_du_reg  <= t5_du_next;
            t6_s_reg   <= t5_s_reg;
            t6_f_reg   <= t5_f_reg;
            t6_u_reg   <= t5_u_reg;
            t6_ds_reg  <= t5_ds_reg;
            t6_df_reg  <= t5_df_reg;
            t6_du_reg  <= t6_du_next;
            t7_res_reg <= t7_res_next;
        end
    end

    // ---------------- output register and skid entry ----------------
    logic leave;
    logic take_out;

    assign leave    = adv && t7_valid_reg;
    assign take_out = !res_valid_reg || !res_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (take_out)
        begin
            res_valid_reg  <= skid_valid_reg || leave;
            skid_valid_reg <= 1'b0;
        end
        else if (leave)
        begin
            // output held: park the transaction leaving the pipeline
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take_out)
        begin
            res_reg <= skid_valid_reg ? skid_reg : t7_res_reg;
        end
        else if (leave)
        begin
            skid_reg <= t7_res_reg;
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    // ---------------- assertions ----------------
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> res_valid_reg)
        else $error("skid entry occupied with empty output register");

    a_skid_fill_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(skid_valid_reg) |-> $past(res_valid_reg && res_stall))
        else $error("skid filled without a stalled output");

    a_pipe_frozen: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |=> $stable(t7_valid_reg))
        else $error("pipeline moved while skid entry occupied");

endmodule

`default_nettype wire
